// ===== rtl/smpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package smpd_pkg;
   localparam int MAX_PACKET_BYTES = 8;
   localparam int COORD_BITS = 12;
   localparam int IDX_BITS = $clog2(MAX_PACKET_BYTES);
   localparam int CNT_BITS = $clog2(MAX_PACKET_BYTES + 1);
   localparam int REM_BITS = 11;

   localparam logic [3:0] PROTO_NONE = 4'd0;
   localparam logic [3:0] PROTO_MS = 4'd1;
   localparam logic [3:0] PROTO_MSC = 4'd2;
   localparam logic [3:0] PROTO_BUS = 4'd3;
   localparam logic [3:0] PROTO_MM = 4'd4;
   localparam logic [3:0] PROTO_LOGI = 4'd5;
   localparam logic [3:0] PROTO_PS2 = 4'd6;
   localparam logic [3:0] PROTO_IMPS2 = 4'd7;
   localparam logic [3:0] PROTO_EXPS2 = 4'd8;

   localparam logic [2:0] REG_PROTOCOL = 3'd0;
   localparam logic [2:0] REG_SYNC_MASK = 3'd1;
   localparam logic [2:0] REG_SYNC_ID = 3'd2;
   localparam logic [2:0] REG_PACKET_LENGTH = 3'd3;
   localparam logic [2:0] REG_CELL_WIDTH = 3'd4;
   localparam logic [2:0] REG_CELL_HEIGHT = 3'd5;
   localparam logic [2:0] REG_SCREEN_COLUMNS = 3'd6;
   localparam logic [2:0] REG_SCREEN_ROWS = 3'd7;

   typedef struct packed {
      logic start;
      logic signed [REM_BITS+1:0] dividend;
      logic [6:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic signed [REM_BITS+1:0] quotient;
      logic signed [REM_BITS-1:0] remainder;
   } div_rsp_type;
endpackage
`default_nettype wire

// ===== rtl/smpd_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring signed divide, one quotient bit per cycle, truncating toward zero.
module smpd_divider (
   input wire logic clock,
   input wire logic reset,
   input wire smpd_pkg::div_req_type req,
   output smpd_pkg::div_rsp_type rsp
);
   localparam int W = smpd_pkg::REM_BITS + 2;
   logic busy_ff, busy_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [W-1:0] quo_ff, quo_in;
   logic [7:0] rem_ff, rem_in;
   logic [6:0] dvs_ff, dvs_in;
   logic neg_ff, neg_in;
   logic done_ff, done_in;
   logic [8:0] trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[W-1]} - {2'b00, dvs_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = 5'(W);
         neg_in = req.dividend[W-1];
         quo_in = req.dividend[W-1] ? W'(-req.dividend) : W'(req.dividend);
         rem_in = '0;
         dvs_in = req.divisor;
      end else if (busy_ff) begin
         if (!trial[8]) begin
            rem_in = trial[7:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[6:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
   assign rsp.remainder = neg_ff ? smpd_pkg::REM_BITS'(-$signed({3'b000, rem_ff}))
                                 : smpd_pkg::REM_BITS'(rem_ff);

`ifndef SYNTH
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < {1'b0, dvs_ff}) else $error("remainder too large");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cnt_ff != 5'd1 |=> busy_ff) else $error("divider quit early");
`endif
endmodule
`default_nettype wire

// ===== rtl/serial_mouse_packet_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a non-final byte is taken and the input stays ready; the final byte of a packet gives its
// result beat through a setup state, two divides through the one shared divider, and an output
// state, in that order.
// Flow: the input is not ready from a final byte until its result is loaded into the output register;
// a result beat still held at the output stalls the output step.
// Synchronous active-high reset restores register defaults, clears byte count, cursor, remainders.
module serial_mouse_packet_decoder_top (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [7:0] req_data_byte,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [4:0] rsp_buttons,
   output logic [11:0] rsp_column,
   output logic [11:0] rsp_row,
   output logic rsp_moved,
   input wire logic csr_write,
   input wire logic [2:0] csr_index,
   input wire logic [11:0] csr_data
);
   localparam int RB = smpd_pkg::REM_BITS;
   localparam int CB = smpd_pkg::COORD_BITS;
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DX = 3'd1;
   localparam logic [2:0] ST_WX = 3'd2;
   localparam logic [2:0] ST_WY = 3'd3;
   localparam logic [2:0] ST_MOVE = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   logic [3:0] protocol_ff;
   logic [7:0] sync_mask_ff, sync_id_ff;
   logic [3:0] plen_ff;
   logic [6:0] cw_ff, ch_ff;
   logic [11:0] cols_ff, rows_ff;
   logic [2:0] state_ff, state_in;
   logic [smpd_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [7:0] store_ff [smpd_pkg::MAX_PACKET_BYTES];
   logic signed [RB-1:0] remx_ff, remx_in, remy_ff, remy_in;
   logic [CB-1:0] col_ff, col_in, row_ff, row_in;
   logic signed [RB+1:0] qx_ff, qx_in, sumy_ff, sumy_in;
   logic [4:0] btn_ff, btn_in;
   logic moved_ff, moved_in;
   logic out_valid_ff, out_valid_in;
   logic [4:0] out_btn_ff;
   logic [CB-1:0] out_col_ff, out_row_ff;
   logic out_moved_ff;
   logic out_load;
   smpd_pkg::div_req_type dreq;
   smpd_pkg::div_rsp_type drsp;

   logic [3:0] eff_len;
   logic proto_ok, abort, accept, last;
   logic [7:0] dmask;
   logic [7:0] b0, b1, b2, b3, b5, b6;
   logic [4:0] bt;
   logic signed [RB+1:0] mx, my, wheel;
   logic [6:0] cw_eff, ch_eff;
   logic signed [CB+1:0] ncol, nrow;
   logic [CB-1:0] colmax, rowmax;

   function automatic logic signed [RB+1:0] sx8(input logic [7:0] v);
      return (RB+2)'($signed(v));
   endfunction
   function automatic logic signed [RB+1:0] sx7(input logic [7:0] v);
      return (RB+2)'($signed(v[6:0]));
   endfunction

   assign eff_len = (plen_ff < 4'd3) ? 4'd3 :
      (plen_ff > 4'(smpd_pkg::MAX_PACKET_BYTES)) ? 4'(smpd_pkg::MAX_PACKET_BYTES) : plen_ff;
   assign proto_ok = protocol_ff >= smpd_pkg::PROTO_MS && protocol_ff <= smpd_pkg::PROTO_EXPS2;
   assign dmask = (protocol_ff == smpd_pkg::PROTO_MS) ? 8'h40 :
      (protocol_ff == smpd_pkg::PROTO_MM || protocol_ff == smpd_pkg::PROTO_LOGI) ? 8'h80 : 8'h00;
   assign abort = protocol_ff <= smpd_pkg::PROTO_LOGI &&
      (((req_data_byte & dmask) != 8'h00) || req_data_byte == 8'h80);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign last = cnt_ff != '0 && !abort && ({1'b0, cnt_ff} + 5'd1 >= {1'b0, eff_len});
   assign cw_eff = (cw_ff == 7'd0) ? 7'd1 : cw_ff;
   assign ch_eff = (ch_ff == 7'd0) ? 7'd1 : ch_ff;
   assign out_load = (state_ff == ST_OUT) && (!out_valid_ff || rsp_ready);

   function automatic logic [7:0] byte_at(input int i, input logic [3:0] n,
                                         input logic [7:0] s);
      return (i < int'(n)) ? s : 8'h00;
   endfunction

   always_comb begin
      b0 = store_ff[0];
      b1 = store_ff[1];
      b2 = store_ff[2];
      b3 = byte_at(3, eff_len, store_ff[3]);
      b5 = byte_at(5, eff_len, store_ff[5]);
      b6 = byte_at(6, eff_len, store_ff[6]);
      bt = '0;
      mx = '0;
      my = '0;
      wheel = '0;
      unique case (protocol_ff)
         smpd_pkg::PROTO_MS: begin
            bt = {2'b00, b0[4], 1'b0, b0[5]};
            mx = sx8({b0[1:0], b1[5:0]});
            my = sx8({b0[3:2], b2[5:0]});
         end
         smpd_pkg::PROTO_MSC: begin
            bt = {2'b00, ~b0[0], ~b0[1], ~b0[2]};
            mx = sx8(b1) + sx8(b3);
            my = -(sx8(b2) + sx8(byte_at(4, eff_len, store_ff[4])));
            if (eff_len >= 4'd8) wheel = sx7(b5) + sx7(b6);
         end
         smpd_pkg::PROTO_BUS: begin
            bt = {2'b00, ~b0[0], ~b0[1], ~b0[2]};
            mx = sx8(b1);
            my = -sx8(b2);
         end
         smpd_pkg::PROTO_MM, smpd_pkg::PROTO_LOGI: begin
            bt = {2'b00, b0[0], b0[1], b0[2]};
            mx = b0[4] ? (RB+2)'({1'b0, b1}) : -(RB+2)'({1'b0, b1});
            my = b0[3] ? -(RB+2)'({1'b0, b2}) : (RB+2)'({1'b0, b2});
         end
         default: begin
            bt = {2'b00, b0[1], b0[2], b0[0]};
            mx = sx8(b1);
            my = -sx8(b2);
            if (protocol_ff == smpd_pkg::PROTO_IMPS2) wheel = sx8(b3);
            else if (protocol_ff == smpd_pkg::PROTO_EXPS2) wheel = (RB+2)'($signed(b3[3:0]));
         end
      endcase
      if (wheel < 0) bt[3] = 1'b1;
      if (wheel > 0) bt[4] = 1'b1;
   end

   assign colmax = (cols_ff == 12'd0) ? '0 : CB'(cols_ff - 12'd1);
   assign rowmax = (rows_ff == 12'd0) ? '0 : CB'(rows_ff - 12'd1);
   assign ncol = $signed({2'b00, col_ff}) + (CB+2)'(qx_ff);
   assign nrow = $signed({2'b00, row_ff}) + (CB+2)'(drsp.quotient);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      remx_in = remx_ff;
      remy_in = remy_ff;
      col_in = col_ff;
      row_in = row_ff;
      qx_in = qx_ff;
      sumy_in = sumy_ff;
      btn_in = btn_ff;
      moved_in = moved_ff;
      out_valid_in = out_valid_ff;
      dreq = '0;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && proto_ok) begin
               if (cnt_ff == '0) begin
                  if ((req_data_byte & sync_mask_ff) == sync_id_ff)
                     cnt_in = smpd_pkg::CNT_BITS'(1);
               end else if (abort) begin
                  cnt_in = '0;
               end else if (last) begin
                  cnt_in = '0;
                  state_in = ST_DX;
               end else begin
                  cnt_in = cnt_ff + smpd_pkg::CNT_BITS'(1);
               end
            end
         end
         ST_DX: begin
            btn_in = bt;
            dreq.start = 1'b1;
            dreq.dividend = (RB+2)'(remx_ff) + mx;
            dreq.divisor = cw_eff;
            sumy_in = (RB+2)'(remy_ff) + my;
            state_in = ST_WX;
         end
         ST_WX: begin
            if (drsp.done) begin
               qx_in = drsp.quotient;
               remx_in = drsp.remainder;
               dreq.start = 1'b1;
               dreq.dividend = sumy_ff;
               dreq.divisor = ch_eff;
               state_in = ST_WY;
            end
         end
         ST_WY: begin
            if (drsp.done) begin
               remy_in = drsp.remainder;
               moved_in = qx_ff != '0 || drsp.quotient != '0;
               if (qx_ff != '0 || drsp.quotient != '0) begin
                  col_in = ncol < 0 ? '0 : (ncol > $signed({2'b00, colmax}) ? colmax
                           : CB'(ncol));
                  row_in = nrow < 0 ? '0 : (nrow > $signed({2'b00, rowmax}) ? rowmax
                           : CB'(nrow));
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (out_load) begin
               out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_ff <= smpd_pkg::PROTO_NONE;
         sync_mask_ff <= '0;
         sync_id_ff <= '0;
         plen_ff <= 4'd3;
         cw_ff <= 7'd8;
         ch_ff <= 7'd16;
         cols_ff <= 12'd80;
         rows_ff <= 12'd25;
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         remx_ff <= '0;
         remy_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               smpd_pkg::REG_PROTOCOL: protocol_ff <= csr_data[3:0];
               smpd_pkg::REG_SYNC_MASK: sync_mask_ff <= csr_data[7:0];
               smpd_pkg::REG_SYNC_ID: sync_id_ff <= csr_data[7:0];
               smpd_pkg::REG_PACKET_LENGTH: plen_ff <= csr_data[3:0];
               smpd_pkg::REG_CELL_WIDTH: cw_ff <= csr_data[6:0];
               smpd_pkg::REG_CELL_HEIGHT: ch_ff <= csr_data[6:0];
               smpd_pkg::REG_SCREEN_COLUMNS: cols_ff <= csr_data;
               smpd_pkg::REG_SCREEN_ROWS: rows_ff <= csr_data;
               default: ;
            endcase
         end
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         remx_ff <= remx_in;
         remy_ff <= remy_in;
         col_ff <= col_in;
         row_ff <= row_in;
         out_valid_ff <= out_valid_in;
      end
      qx_ff <= qx_in;
      sumy_ff <= sumy_in;
      btn_ff <= btn_in;
      moved_ff <= moved_in;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_btn_ff <= btn_ff;
         out_col_ff <= col_ff;
         out_row_ff <= row_ff;
         out_moved_ff <= moved_ff;
      end
   end

   // store: only index below 8 written
   always_ff @(posedge clock) begin
      if (accept && proto_ok && (cnt_ff == '0 || !abort) &&
          cnt_ff < smpd_pkg::CNT_BITS'(smpd_pkg::MAX_PACKET_BYTES))
         store_ff[cnt_ff[smpd_pkg::IDX_BITS-1:0]] <= req_data_byte;
   end

   smpd_divider u_div (
      .clock(clock),
      .reset(reset),
      .req(dreq),
      .rsp(drsp)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_buttons = out_btn_ff;
   assign rsp_column = out_col_ff;
   assign rsp_row = out_row_ff;
   assign rsp_moved = out_moved_ff;

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready) else $error("ready while busy");
   a_out_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == ST_OUT) else $error("stray result");
   a_col_clamped: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff) == ST_WY && state_ff == ST_OUT && moved_ff |-> col_ff <= colmax)
      else $error("column clamp");
`endif
endmodule
`default_nettype wire
